// ===== hw/rtl/toeq_pkg.sv =====
// Shared types, sizes and request codes for the time-ordered event queue.
// No dependencies; every other RTL file refers to this package by scoped names.
package toeq_pkg;

    // Storage sizes
    localparam int DEPTH     = 16;
    localparam int TIME_BITS = 32;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);

    // Fixed field widths of the words on the ports
    localparam int REQ_W     = 2;
    localparam int EVT_TIME_W = 32;
    localparam int KIND_W    = 8;
    localparam int PAY_W     = 32;
    localparam int FILL_W    = 5;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ORDERED = 2'd0;
    localparam logic [REQ_W-1:0] REQ_HEAD    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_POP     = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE    = 2'd3;

    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [TIME_BITS-1:0] t_time;

    // Input word
    typedef struct packed {
        logic [REQ_W-1:0]      req_type;
        logic [EVT_TIME_W-1:0] event_time;
        logic [KIND_W-1:0]     event_kind;
        logic [PAY_W-1:0]      event_payload;
    } t_req_word;

    // Output word
    typedef struct packed {
        logic                  ok;
        logic [EVT_TIME_W-1:0] out_time;
        logic [KIND_W-1:0]     out_kind;
        logic [PAY_W-1:0]      out_payload;
        logic [FILL_W-1:0]     fill_level;
    } t_rsp_word;

    // One stored event
    typedef struct packed {
        t_time             ev_time;
        logic [KIND_W-1:0] ev_kind;
        logic [PAY_W-1:0]  ev_payload;
    } t_entry;

    // Per-cycle command broadcast to every cell
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     at_head;
        t_cnt     count;
        t_entry   new_entry;
    } t_cell_ctl;

    // Narrow or widen a port time stamp to the stored width
    function automatic t_time to_slot_time(input logic [EVT_TIME_W-1:0] t);
        logic [63:0] w;
        w = 64'(t);
        return w[TIME_BITS-1:0];
    endfunction

    // Bring a stored time stamp back to the port width
    function automatic logic [EVT_TIME_W-1:0] to_port_time(input t_time t);
        logic [63:0] w;
        w = 64'(t);
        return w[EVT_TIME_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/toeq_cell.sv =====
// One slot of the sorted event chain: holds an event and trades it with its neighbors.
// Depends on toeq_pkg for the entry, command and index types.
module toeq_cell (
    input  logic                  i_clk,
    input  toeq_pkg::t_idx        i_idx,
    input  toeq_pkg::t_cell_ctl   i_ctl,
    input  logic                  i_prev_keep,
    input  toeq_pkg::t_entry      i_prev_entry,
    input  toeq_pkg::t_entry      i_next_entry,
    output logic                  o_keep,
    output toeq_pkg::t_entry      o_entry
);

    toeq_pkg::t_entry r_entry;
    toeq_pkg::t_entry n_entry;
    logic             occupied;
    logic             not_later;

    // Decide whether this slot stays in front of the new event
    assign occupied  = toeq_pkg::t_cnt'(i_idx) < i_ctl.count;
    assign not_later = occupied && !i_ctl.at_head
                       && (r_entry.ev_time <= i_ctl.new_entry.ev_time);
    assign o_keep    = i_prev_keep && not_later;

    // Pick the next content: hold, take the new event, shift down or shift up
    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            toeq_pkg::CELL_INSERT: begin
                if (o_keep) begin
                    n_entry = r_entry;
                end else if (i_prev_keep) begin
                    n_entry = i_ctl.new_entry;
                end else begin
                    n_entry = i_prev_entry;
                end
            end
            toeq_pkg::CELL_POP: begin
                n_entry = i_next_entry;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ===== hw/rtl/time_ordered_event_queue.sv =====
// Top level of the time-ordered event queue: request handshake, count and result register.
// Depends on toeq_pkg and instantiates a chain of toeq_cell slots.
//
//   channel   direction  handshake              word
//   request   in         i_valid / o_stall      i_req  (toeq_pkg::t_req_word)
//   result    out        o_valid / i_stall      o_rsp  (toeq_pkg::t_rsp_word)
//
// Every request gives one result word in the next cycle.
// A new request is taken each cycle while the result register is empty or drained;
// the insert position is found by one pass of the keep chain through all slots.
// Reset clears the count and the result valid; slot contents need no clearing.
// o_stall rises only while a result is held by i_stall.
module time_ordered_event_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  toeq_pkg::t_req_word   i_req,
    output logic                  o_valid,
    input  logic                  i_stall,
    output toeq_pkg::t_rsp_word   o_rsp
);

    logic                 r_valid;
    logic                 n_valid;
    toeq_pkg::t_rsp_word  r_rsp;
    toeq_pkg::t_rsp_word  n_rsp;
    toeq_pkg::t_cnt       r_count;
    toeq_pkg::t_cnt       n_count;

    logic                 accept;
    logic                 is_full;
    logic                 is_empty;
    logic                 is_insert;
    logic                 is_pop;
    toeq_pkg::t_cell_ctl  ctl;

    logic             keep  [toeq_pkg::DEPTH+1];
    toeq_pkg::t_entry entry [toeq_pkg::DEPTH];

    assign o_stall = r_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    assign is_full   = r_count == toeq_pkg::t_cnt'(toeq_pkg::DEPTH);
    assign is_empty  = r_count == '0;
    assign is_insert = (i_req.req_type == toeq_pkg::REQ_ORDERED
                        || i_req.req_type == toeq_pkg::REQ_HEAD) && !is_full;
    assign is_pop    = (i_req.req_type == toeq_pkg::REQ_POP) && !is_empty;

    // Build the command broadcast to the slots
    always_comb begin
        ctl.count               = r_count;
        ctl.at_head             = i_req.req_type == toeq_pkg::REQ_HEAD;
        ctl.new_entry.ev_time   = toeq_pkg::to_slot_time(i_req.event_time);
        ctl.new_entry.ev_kind   = i_req.event_kind;
        ctl.new_entry.ev_payload = i_req.event_payload;
        if (accept && is_insert) begin
            ctl.op = toeq_pkg::CELL_INSERT;
        end else if (accept && is_pop) begin
            ctl.op = toeq_pkg::CELL_POP;
        end else begin
            ctl.op = toeq_pkg::CELL_HOLD;
        end
    end

    // Chain of slots, head at index zero
    assign keep[0] = 1'b1;

    for (genvar g = 0; g < toeq_pkg::DEPTH; g++) begin : g_cell
        toeq_pkg::t_entry prev_entry;
        toeq_pkg::t_entry next_entry;

        if (g == 0) begin : g_first
            assign prev_entry = ctl.new_entry;
        end else begin : g_mid
            assign prev_entry = entry[g-1];
        end

        if (g == toeq_pkg::DEPTH - 1) begin : g_last
            assign next_entry = entry[g];
        end else begin : g_inner
            assign next_entry = entry[g+1];
        end

        toeq_cell u_cell (
            .i_clk        (i_clk),
            .i_idx        (toeq_pkg::t_idx'(g)),
            .i_ctl        (ctl),
            .i_prev_keep  (keep[g]),
            .i_prev_entry (prev_entry),
            .i_next_entry (next_entry),
            .o_keep       (keep[g+1]),
            .o_entry      (entry[g])
        );
    end

    // Form the result word and the new count
    always_comb begin
        n_count = r_count;
        n_rsp   = r_rsp;
        n_valid = r_valid && i_stall;
        if (accept) begin
            n_valid           = 1'b1;
            n_rsp.ok          = is_insert || is_pop;
            n_rsp.out_time    = '0;
            n_rsp.out_kind    = '0;
            n_rsp.out_payload = '0;
            if (is_insert) begin
                n_count = r_count + toeq_pkg::t_cnt'(1);
            end else if (is_pop) begin
                n_count           = r_count - toeq_pkg::t_cnt'(1);
                n_rsp.out_time    = toeq_pkg::to_port_time(entry[0].ev_time);
                n_rsp.out_kind    = entry[0].ev_kind;
                n_rsp.out_payload = entry[0].ev_payload;
            end
            n_rsp.fill_level = toeq_pkg::FILL_W'(n_count);
        end
    end

    // Hold control state and the result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
        end
        r_rsp <= n_rsp;
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

// ===== hw/rtl/toeq_checker.sv =====
// Port-level checks for the time-ordered event queue, bound to the top level.
// Depends on toeq_pkg for the word types and the queue depth.
module toeq_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  o_stall,
    input  toeq_pkg::t_req_word   i_req,
    input  logic                  o_valid,
    input  logic                  i_stall,
    input  toeq_pkg::t_rsp_word   o_rsp
);

    // Hold a stalled result word
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rsp))
        else $error("result word changed while stalled");

    // Drop the result register on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Never report more events than slots
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_rsp.fill_level <= toeq_pkg::FILL_W'(toeq_pkg::DEPTH))
        else $error("fill level beyond depth");

    // Zero the event fields of a refused request
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_rsp.ok |-> o_rsp.out_time == '0 && o_rsp.out_kind == '0
                                  && o_rsp.out_payload == '0)
        else $error("refused request carries event data");

    // Refuse a pop only when the list stays empty
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_req.req_type == toeq_pkg::REQ_POP
        |=> o_valid && (o_rsp.ok || o_rsp.fill_level == '0))
        else $error("pop refused with events stored");

endmodule

bind time_ordered_event_queue toeq_checker u_toeq_checker (.*);

// ===== tb/sv/time_ordered_event_queue_tb.sv =====
// Self-checking testbench for the time-ordered event queue: directed, fill/drain,
// back-pressure and random request streams checked against an in-bench list model.
// Depends on toeq_pkg and the time_ordered_event_queue RTL.
module time_ordered_event_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PER_PHASE = 300;
    localparam int HOLD_CYCLES      = 150;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                i_stall = 1'b0;
    toeq_pkg::t_req_word i_req   = '0;
    logic                o_stall;
    logic                o_valid;
    toeq_pkg::t_rsp_word o_rsp;

    // Model of the stored events, head first, and the words still to come out
    toeq_pkg::t_entry    event_list[$];
    toeq_pkg::t_rsp_word pending_results[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_len      = 0;
    bit filling       = 1'b1;

    int err_count     = 0;
    int n_checked     = 0;
    int n_inserted    = 0;
    int n_refused     = 0;
    int n_popped      = 0;
    int n_empty_pops  = 0;
    int n_max_fill    = 0;

    time_ordered_event_queue DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    always #1 i_clk = ~i_clk;

    // Hard stop in case a handshake never completes
    initial begin
        #1ms;
        $display("tb: failure");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        err_count++;
    endtask

    // Apply one request to the list model and return the word it should produce
    function automatic toeq_pkg::t_rsp_word apply_request(input toeq_pkg::t_req_word w);
        toeq_pkg::t_rsp_word r;
        toeq_pkg::t_entry    e;
        toeq_pkg::t_time     t;
        int                  pos;
        r = '0;
        t = toeq_pkg::t_time'(w.event_time);
        e.ev_time    = t;
        e.ev_kind    = w.event_kind;
        e.ev_payload = w.event_payload;
        case (w.req_type)
            toeq_pkg::REQ_ORDERED, toeq_pkg::REQ_HEAD: begin
                if (event_list.size() < toeq_pkg::DEPTH) begin
                    pos = 0;
                    // walk past every stored event that is not later than this one
                    if (w.req_type == toeq_pkg::REQ_ORDERED) begin
                        while (pos < event_list.size() && event_list[pos].ev_time <= t)
                            pos++;
                    end
                    event_list.insert(pos, e);
                    r.ok = 1'b1;
                end
            end
            toeq_pkg::REQ_POP: begin
                if (event_list.size() > 0) begin
                    e = event_list.pop_front();
                    r.ok          = 1'b1;
                    r.out_time    = toeq_pkg::EVT_TIME_W'(e.ev_time);
                    r.out_kind    = e.ev_kind;
                    r.out_payload = e.ev_payload;
                end
            end
            default: ;
        endcase
        r.fill_level = toeq_pkg::FILL_W'(event_list.size());
        return r;
    endfunction

    function automatic toeq_pkg::t_req_word req_word(
            input logic [toeq_pkg::REQ_W-1:0]      req,
            input logic [toeq_pkg::EVT_TIME_W-1:0] t,
            input logic [toeq_pkg::KIND_W-1:0]     kind,
            input logic [toeq_pkg::PAY_W-1:0]      pay);
        toeq_pkg::t_req_word w;
        w.req_type      = req;
        w.event_time    = t;
        w.event_kind    = kind;
        w.event_payload = pay;
        return w;
    endfunction

    // Random request; leans toward inserts while filling and pops while draining
    function automatic toeq_pkg::t_req_word random_request();
        toeq_pkg::t_req_word w;
        int                  roll;
        roll = $urandom_range(99);
        if (roll < 4)
            w.req_type = toeq_pkg::REQ_NONE;
        else if (roll < (filling ? 72 : 30))
            w.req_type = ($urandom_range(4) == 0) ? toeq_pkg::REQ_HEAD
                                                  : toeq_pkg::REQ_ORDERED;
        else
            w.req_type = toeq_pkg::REQ_POP;
        case ($urandom_range(3))
            0: w.event_time = $urandom_range(7);
            1: w.event_time = '1 - $urandom_range(7);
            2: w.event_time = $urandom_range(1) ? '1 : '0;
            default: w.event_time = $urandom;
        endcase
        w.event_kind    = toeq_pkg::KIND_W'($urandom_range(255));
        w.event_payload = $urandom;
        return w;
    endfunction

    // Offer one word, hold it until taken, then record the expected result
    task automatic send_word(input toeq_pkg::t_req_word w);
        toeq_pkg::t_rsp_word r;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            i_req   <= random_request();
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_req   <= w;
        do @(posedge i_clk); while (o_stall);
        r = apply_request(w);
        pending_results.push_back(r);
        if (event_list.size() > n_max_fill)
            n_max_fill = event_list.size();
        case (w.req_type)
            toeq_pkg::REQ_ORDERED, toeq_pkg::REQ_HEAD:
                if (r.ok) n_inserted++; else n_refused++;
            toeq_pkg::REQ_POP:
                if (r.ok) n_popped++;   else n_empty_pops++;
            default: ;
        endcase
        // switch direction at the ends of the list
        if (event_list.size() == toeq_pkg::DEPTH)
            filling = 1'b0;
        else if (event_list.size() == 0)
            filling = 1'b1;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Receiver: hold off for a counted stretch on request, otherwise stall at random
    always @(negedge i_clk) begin
        if (hold_len > 0) begin
            i_stall  <= 1'b1;
            hold_len <= hold_len - 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Check each accepted result word against the oldest expectation
    always @(posedge i_clk) begin : check_result
        toeq_pkg::t_rsp_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result word %h with nothing expected", o_rsp));
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (o_rsp.ok !== want.ok)
                    report_mismatch($sformatf("ok %b, want %b", o_rsp.ok, want.ok));
                if (o_rsp.out_time !== want.out_time)
                    report_mismatch($sformatf("out_time %h, want %h",
                                              o_rsp.out_time, want.out_time));
                if (o_rsp.out_kind !== want.out_kind)
                    report_mismatch($sformatf("out_kind %h, want %h",
                                              o_rsp.out_kind, want.out_kind));
                if (o_rsp.out_payload !== want.out_payload)
                    report_mismatch($sformatf("out_payload %h, want %h",
                                              o_rsp.out_payload, want.out_payload));
                if (o_rsp.fill_level !== want.fill_level)
                    report_mismatch($sformatf("fill_level %0d, want %0d",
                                              o_rsp.fill_level, want.fill_level));
            end
        end
    end

    // Empty list, extreme fields, ties, head insert and the unused code
    task automatic test_directed();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_word(req_word(toeq_pkg::REQ_POP, 32'h1234_5678, 8'h5A, 32'hDEAD_BEEF));
        send_word(req_word(toeq_pkg::REQ_NONE, '1, '1, '1));
        send_word(req_word(toeq_pkg::REQ_ORDERED, '1, '1, '1));
        send_word(req_word(toeq_pkg::REQ_ORDERED, '0, '0, '0));
        send_word(req_word(toeq_pkg::REQ_ORDERED, 32'd5, 8'h01, 32'hA000_0001));
        send_word(req_word(toeq_pkg::REQ_ORDERED, 32'd5, 8'h02, 32'hA000_0002));
        send_word(req_word(toeq_pkg::REQ_ORDERED, 32'd5, 8'h03, 32'hA000_0003));
        send_word(req_word(toeq_pkg::REQ_HEAD, '1, 8'hC3, 32'h5555_AAAA));
        send_word(req_word(toeq_pkg::REQ_NONE, 32'd9, 8'h77, 32'h0F0F_0F0F));
        repeat (toeq_pkg::DEPTH > 7 ? 7 : toeq_pkg::DEPTH)
            send_word(req_word(toeq_pkg::REQ_POP, '0, '0, '0));
    endtask

    // Fill to the limit, try inserts on a full list, then drain past empty
    task automatic test_fill_and_drain();
        toeq_pkg::t_req_word w;
        send_idle_pct = 23;
        recv_idle_pct = 59;
        while (event_list.size() < toeq_pkg::DEPTH) begin
            w = random_request();
            w.req_type = toeq_pkg::REQ_ORDERED;
            send_word(w);
        end
        send_word(req_word(toeq_pkg::REQ_ORDERED, 32'd1, 8'h11, 32'h1111_1111));
        send_word(req_word(toeq_pkg::REQ_HEAD, 32'd2, 8'h22, 32'h2222_2222));
        while (event_list.size() > 0)
            send_word(req_word(toeq_pkg::REQ_POP, $urandom,
                               toeq_pkg::KIND_W'($urandom_range(255)), $urandom));
        send_word(req_word(toeq_pkg::REQ_POP, '0, '0, '0));
    endtask

    // Long receiver hold-off with the sender still offering, then a sender pause
    task automatic test_back_pressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_len = HOLD_CYCLES;
        repeat (20)
            send_word(random_request());
        wait_drained();
        repeat (10)
            send_word(random_request());
    endtask

    task automatic test_random(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (RANDOM_PER_PHASE)
            send_word(random_request());
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_fill_and_drain();
        test_back_pressure();
        test_random(23, 59);
        test_random(59, 23);
        test_random(0, 0);

        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("summary: %0d words checked, %0d inserts (%0d refused as full)",
                 n_checked, n_inserted + n_refused, n_refused);
        $display("summary: %0d pops (%0d on empty list), peak fill %0d of %0d",
                 n_popped + n_empty_pops, n_empty_pops, n_max_fill, toeq_pkg::DEPTH);
        if (err_count == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== time_ordered_event_queue.f =====
hw/rtl/toeq_pkg.sv
hw/rtl/toeq_cell.sv
hw/rtl/time_ordered_event_queue.sv
hw/rtl/toeq_checker.sv
tb/sv/time_ordered_event_queue_tb.sv
